/* rtl/css_pkg.sv */
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the column statistics unit.
// ----------------------------------------------------------------------------
package css_pkg;

   localparam logic [1:0] KIND_MISSING = 2'd0;
   localparam logic [1:0] KIND_WORD    = 2'd1;
   localparam logic [1:0] KIND_NUMBER  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_UNDEFINED = 2'd1;
   localparam logic [1:0] STAT_MISSING   = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

   localparam int MAG_BITS  = 49;  // magnitude of a Q16.32 difference
   localparam int PROD_BITS = 2 * MAG_BITS;
   localparam int DIV_STEPS = 64;
   localparam int MUL_STEPS = MAG_BITS;
   localparam int SQRT_STEPS = 32;

   typedef struct packed {
      logic take;         // accept the input beat into the statistics
      logic div_load;     // start the shared divider
      logic div_var;      // divider operands: variance (1) or mean step (0)
      logic apply_mean;   // fold the quotient into the running mean
      logic mul_load;     // start the delta product
      logic accum;        // add the product into M2
      logic sqrt_load;    // latch variance and start the root
      logic load_out;     // fill the result register, clear the statistics
   } cmd_type;

   typedef struct packed {
      logic is_update;    // the beat on the input is a countable number
      logic div_busy;
      logic mul_busy;
      logic sqrt_busy;
      logic result_ok;    // column statistics are defined
   } status_type;

endpackage

/* rtl/css_ctrl.sv */
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer for the per-cell update and the end-of-column result.
// ----------------------------------------------------------------------------
module css_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_in_column,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  css_pkg::status_type st,
   output css_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_STEP_DIV, S_MUL_LOAD, S_MUL, S_FINISH, S_VAR_DIV, S_SQRT, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      last_in  = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take     = 1'b1;
               cmd.div_load = st.is_update;
               last_in      = req_last_in_column;
               if (st.is_update)
                  state_in = S_STEP_DIV;
               else if (req_last_in_column)
                  state_in = S_FINISH;
            end
         end
         S_STEP_DIV: begin
            if (!st.div_busy) begin
               cmd.apply_mean = 1'b1;
               state_in       = S_MUL_LOAD;
            end
         end
         S_MUL_LOAD: begin
            cmd.mul_load = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            if (!st.mul_busy) begin
               cmd.accum = 1'b1;
               state_in  = last_ff ? S_FINISH : S_IDLE;
            end
         end
         S_FINISH: begin
            if (st.result_ok) begin
               cmd.div_load = 1'b1;
               cmd.div_var  = 1'b1;
               state_in     = S_VAR_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_VAR_DIV: begin
            if (!st.div_busy) begin
               cmd.sqrt_load = 1'b1;
               state_in      = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!st.sqrt_busy)
               state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/css_datapath.sv */
// ----------------------------------------------------------------------------
// css_datapath
// Counters, min/max, Welford mean/M2, shared divider, serial multiplier,
// bit-pair square root and the result register.
// ----------------------------------------------------------------------------
module css_datapath #(
   parameter int COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  css_pkg::cmd_type    cmd,
   output css_pkg::status_type st,
   input  logic [1:0]          req_cell_kind,
   input  logic signed [31:0]  req_sample_value,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_mean_value,
   output logic [62:0]         rsp_variance,
   output logic [30:0]         rsp_std_deviation,
   output logic signed [31:0]  rsp_minimum,
   output logic signed [31:0]  rsp_maximum,
   output logic [15:0]         rsp_numeric_count,
   output logic [15:0]         rsp_missing_count,
   output logic [15:0]         rsp_word_count,
   output logic                rsp_all_integer
);

   localparam int MB = css_pkg::MAG_BITS;
   localparam int PB = css_pkg::PROD_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // statistics
   logic [COUNT_BITS-1:0] num_ff, miss_ff, word_ff, whole_ff;
   logic signed [47:0]    mean_ff;
   logic [63:0]           m2_ff;
   logic signed [31:0]    min_ff, max_ff;
   logic                  ovf_ff;
   // current number
   logic signed [47:0]    xq_ff;
   logic [MB-1:0]         magd_ff;
   logic                  dneg_ff;
   // divider
   logic [63:0]           quo_ff;
   logic [COUNT_BITS-1:0] rem_ff, den_ff;
   logic [6:0]            div_cnt_ff;
   // multiplier
   logic [PB-1:0]         prod_ff;
   logic [MB-1:0]         mul_a_ff;
   logic [5:0]            mul_cnt_ff;
   // square root
   logic [63:0]           sq_v_ff, sq_root_ff, sq_bit_ff;
   logic [62:0]           var_ff;
   logic [5:0]            sq_cnt_ff;

   // combinational helpers
   logic signed [47:0]    xq_now;
   logic signed [48:0]    d_now, e_now;
   logic [MB-1:0]         magd_now, mage_now;
   logic [COUNT_BITS:0]   trial;
   logic                  trial_ge;
   logic [MB:0]           mul_sum;
   logic [63:0]           prod_sh, m2_add;
   logic [64:0]           m2_sum;
   logic [63:0]           sq_try;
   logic [COUNT_BITS+1:0] total;
   logic [1:0]            stat_code;
   logic                  ok;
   logic signed [47:0]    mean_next;

   function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   assign xq_now   = {req_sample_value, 16'b0};
   assign d_now    = {xq_now[47], xq_now} - {mean_ff[47], mean_ff};
   assign magd_now = d_now[48] ? MB'(-d_now) : MB'(d_now);
   assign e_now    = {xq_ff[47], xq_ff} - {mean_ff[47], mean_ff};
   assign mage_now = e_now[48] ? MB'(-e_now) : MB'(e_now);

   assign trial    = {rem_ff, quo_ff[63]};
   assign trial_ge = trial >= {1'b0, den_ff};

   assign mul_sum  = {1'b0, prod_ff[PB-1:MB]} + (prod_ff[0] ? {1'b0, mul_a_ff} : '0);
   assign prod_sh  = (prod_ff[PB-1:96] != '0) ? {64{1'b1}} : prod_ff[95:32];
   assign m2_sum   = {1'b0, m2_ff} + {1'b0, prod_sh};
   assign m2_add   = m2_sum[64] ? {64{1'b1}} : m2_sum[63:0];

   assign sq_try   = sq_root_ff + sq_bit_ff;

   assign mean_next = dneg_ff ? mean_ff - quo_ff[47:0] : mean_ff + quo_ff[47:0];

   assign total = {2'b0, num_ff} + {2'b0, miss_ff} + {2'b0, word_ff};
   always_comb begin
      if (total < (COUNT_BITS+2)'(2) || word_ff != '0)
         stat_code = css_pkg::STAT_UNDEFINED;
      else if (miss_ff != '0)
         stat_code = css_pkg::STAT_MISSING;
      else if (ovf_ff)
         stat_code = css_pkg::STAT_OVERFLOW;
      else
         stat_code = css_pkg::STAT_OK;
   end
   assign ok = (stat_code == css_pkg::STAT_OK);

   assign st.is_update = (req_cell_kind == css_pkg::KIND_NUMBER) && (num_ff != COUNT_MAX);
   assign st.div_busy  = (div_cnt_ff != '0);
   assign st.mul_busy  = (mul_cnt_ff != '0);
   assign st.sqrt_busy = (sq_cnt_ff != '0);
   assign st.result_ok = ok;

   // statistics registers
   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         num_ff   <= '0;
         miss_ff  <= '0;
         word_ff  <= '0;
         whole_ff <= '0;
         mean_ff  <= '0;
         m2_ff    <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.take) begin
            case (req_cell_kind)
               css_pkg::KIND_MISSING: begin
                  if (miss_ff == COUNT_MAX) ovf_ff <= 1'b1;
                  else miss_ff <= miss_ff + 1'b1;
               end
               css_pkg::KIND_WORD: begin
                  if (word_ff == COUNT_MAX) ovf_ff <= 1'b1;
                  else word_ff <= word_ff + 1'b1;
               end
               css_pkg::KIND_NUMBER: begin
                  if (req_sample_value[15:0] == 16'd0) begin
                     if (whole_ff == COUNT_MAX) ovf_ff <= 1'b1;
                     else whole_ff <= whole_ff + 1'b1;
                  end
                  if (num_ff == '0) begin
                     min_ff <= req_sample_value;
                     max_ff <= req_sample_value;
                  end else begin
                     if (req_sample_value < min_ff) min_ff <= req_sample_value;
                     if (req_sample_value > max_ff) max_ff <= req_sample_value;
                  end
                  if (num_ff == COUNT_MAX) ovf_ff <= 1'b1;
                  else num_ff <= num_ff + 1'b1;
               end
               default: ;
            endcase
         end
         if (cmd.apply_mean) mean_ff <= mean_next;
         if (cmd.accum)      m2_ff   <= m2_add;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         xq_ff   <= xq_now;
         magd_ff <= magd_now;
         dneg_ff <= d_now[48];
      end
   end

   // shared restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_load) begin
         div_cnt_ff <= 7'(css_pkg::DIV_STEPS);
         rem_ff     <= '0;
         if (cmd.div_var) begin
            quo_ff <= m2_ff;
            den_ff <= num_ff - 1'b1;
         end else begin
            quo_ff <= 64'(magd_now);
            den_ff <= num_ff + 1'b1;
         end
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
         if (trial_ge) begin
            rem_ff <= COUNT_BITS'(trial - {1'b0, den_ff});
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= trial[COUNT_BITS-1:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end

   // shift-add multiplier |d| * |e|
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_cnt_ff <= '0;
      end else if (cmd.mul_load) begin
         mul_cnt_ff <= 6'(css_pkg::MUL_STEPS);
         mul_a_ff   <= magd_ff;
         prod_ff    <= {{MB{1'b0}}, mage_now};
      end else if (mul_cnt_ff != '0) begin
         mul_cnt_ff <= mul_cnt_ff - 1'b1;
         prod_ff    <= {mul_sum, prod_ff[MB-1:1]};
      end
   end

   // square root, two radicand bits per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_cnt_ff <= '0;
      end else if (cmd.sqrt_load) begin
         sq_cnt_ff  <= 6'(css_pkg::SQRT_STEPS);
         sq_root_ff <= '0;
         sq_bit_ff  <= 64'h4000_0000_0000_0000;
         if (quo_ff[63]) begin
            sq_v_ff <= 64'h7FFF_FFFF_FFFF_FFFF;
            var_ff  <= {63{1'b1}};
         end else begin
            sq_v_ff <= quo_ff;
            var_ff  <= quo_ff[62:0];
         end
      end else if (sq_cnt_ff != '0) begin
         sq_cnt_ff <= sq_cnt_ff - 1'b1;
         sq_bit_ff <= {2'b0, sq_bit_ff[63:2]};
         if (sq_v_ff >= sq_try) begin
            sq_v_ff    <= sq_v_ff - sq_try;
            sq_root_ff <= {1'b0, sq_root_ff[63:1]} + sq_bit_ff;
         end else begin
            sq_root_ff <= {1'b0, sq_root_ff[63:1]};
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status        <= stat_code;
         rsp_mean_value    <= ok ? mean_ff[47:16] : '0;
         rsp_variance      <= ok ? var_ff : '0;
         rsp_std_deviation <= !ok ? '0 :
                              (sq_root_ff[63:31] != '0) ? {31{1'b1}} : sq_root_ff[30:0];
         rsp_minimum       <= (num_ff != '0) ? min_ff : '0;
         rsp_maximum       <= (num_ff != '0) ? max_ff : '0;
         rsp_numeric_count <= sat16(num_ff);
         rsp_missing_count <= sat16(miss_ff);
         rsp_word_count    <= sat16(word_ff);
         rsp_all_integer   <= (num_ff != '0) && (whole_ff == num_ff);
      end
   end

endmodule

/* rtl/column_stream_statistics_unit.sv */
// ----------------------------------------------------------------------------
// column_stream_statistics_unit
// Streaming per-column statistics: counts, min/max, Welford mean and variance.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one table cell per beat (kind, Q16.16 value, last mark).
//   A beat moves when valid is high and stall is low. req_stall is low only
//   while the block is idle; each cell is taken whole before the next.
//   Missing, word and unused-kind cells need no arithmetic. A number runs the
//   restoring divider (delta / count, one quotient bit a cycle), then the
//   shift-add product |d|*|e|. The divider and multiplier set the rate.
//   On a cell marked last, one rsp_* beat follows: if the column is valid,
//   the divider runs again for M2 / (n - 1) and the root follows (steps:
//   decide, divide, root, load the result); otherwise the sequencer goes
//   from the decision straight to loading the result.
//   The result sits in an output register; while rsp_stall holds it, a new
//   column may begin, and only a second finished column waits for it.
//   Reset (synchronous, active high) clears all counters and the running
//   mean and M2, and drops rsp_valid. After each result the statistics
//   return to that reset state for the next column.
// ----------------------------------------------------------------------------
module column_stream_statistics_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cell_kind,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_last_in_column,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_mean_value,
   output logic [62:0]        rsp_variance,
   output logic [30:0]        rsp_std_deviation,
   output logic signed [31:0] rsp_minimum,
   output logic signed [31:0] rsp_maximum,
   output logic [15:0]        rsp_numeric_count,
   output logic [15:0]        rsp_missing_count,
   output logic [15:0]        rsp_word_count,
   output logic               rsp_all_integer
);

   css_pkg::cmd_type    cmd;
   css_pkg::status_type st;

   // sequencer: decides which datapath unit runs
   css_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_last_in_column (req_last_in_column),
      .req_stall          (req_stall),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .st                 (st),
      .cmd                (cmd)
   );

   // arithmetic, statistics and result register
   css_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_cell_kind     (req_cell_kind),
      .req_sample_value  (req_sample_value),
      .rsp_status        (rsp_status),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_variance      (rsp_variance),
      .rsp_std_deviation (rsp_std_deviation),
      .rsp_minimum       (rsp_minimum),
      .rsp_maximum       (rsp_maximum),
      .rsp_numeric_count (rsp_numeric_count),
      .rsp_missing_count (rsp_missing_count),
      .rsp_word_count    (rsp_word_count),
      .rsp_all_integer   (rsp_all_integer)
   );

   // non-ok results carry no mean, variance or deviation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != css_pkg::STAT_OK) |->
         (rsp_mean_value == '0) && (rsp_variance == '0) && (rsp_std_deviation == '0))
      else $error("non-ok result carries statistics");

   // no numbers means no range and no all-whole flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_numeric_count == '0) |->
         (rsp_minimum == '0) && (rsp_maximum == '0) && !rsp_all_integer)
      else $error("range reported without numbers");

   // an ok column has an ordered range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == css_pkg::STAT_OK) |-> (rsp_minimum <= rsp_maximum))
      else $error("minimum above maximum");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for column_stream_statistics_unit: streams table
// columns, models counts, min/max and the Welford mean/M2, checks each result.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0] KIND_UNUSED = 2'd3;     // ignored kind, last mark still counts
   localparam int unsigned COUNT_MAX  = 65535;
   localparam logic [62:0] VAR_MAX    = {63{1'b1}};

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] mean_value;
      logic [62:0]        variance;
      logic [30:0]        std_deviation;
      logic signed [31:0] minimum;
      logic signed [31:0] maximum;
      logic [15:0]        numeric_count;
      logic [15:0]        missing_count;
      logic [15:0]        word_count;
      logic               all_integer;
   } column_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cell_kind = css_pkg::KIND_MISSING;
   logic signed [31:0] req_sample_value = '0;
   logic               req_last_in_column = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_mean_value;
   logic [62:0]        rsp_variance;
   logic [30:0]        rsp_std_deviation;
   logic signed [31:0] rsp_minimum;
   logic signed [31:0] rsp_maximum;
   logic [15:0]        rsp_numeric_count;
   logic [15:0]        rsp_missing_count;
   logic [15:0]        rsp_word_count;
   logic               rsp_all_integer;

   column_stream_statistics_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Column statistics model: counts, extremes, Welford mean (Q16.32) and M2
   // ---------------------------------------------------------------------
   int unsigned      num_cnt, miss_cnt, word_cnt, whole_cnt;
   longint           col_mean;
   logic [63:0]      col_m2;
   logic signed [31:0] col_min, col_max;
   bit               col_overflow;

   column_result_type expected_results[$];
   int               error_count = 0;

   // sender burst state
   int               burst_left = 0;

   function automatic void clear_column();
      num_cnt = 0; miss_cnt = 0; word_cnt = 0; whole_cnt = 0;
      col_mean = 0; col_m2 = '0; col_min = '0; col_max = '0;
      col_overflow = 1'b0;
   endfunction

   function automatic void count_up(ref int unsigned cnt);
      if (cnt >= COUNT_MAX) col_overflow = 1'b1;
      else cnt++;
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root, bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic void add_number(logic signed [31:0] x);
      longint       xq, d, e;
      logic [63:0]  step;
      logic [127:0] prod;
      logic [63:0]  inc;
      logic [64:0]  sum;
      if (x[15:0] == 16'd0) count_up(whole_cnt);
      if (num_cnt == 0) begin
         col_min = x;
         col_max = x;
      end else begin
         if (x < col_min) col_min = x;
         if (x > col_max) col_max = x;
      end
      if (num_cnt >= COUNT_MAX) begin
         col_overflow = 1'b1;
         return;
      end
      num_cnt++;
      xq = longint'(x) * 65536;
      d = xq - col_mean;
      step = magnitude(d) / 64'(num_cnt);
      col_mean = d < 0 ? col_mean - longint'(step) : col_mean + longint'(step);
      e = xq - col_mean;
      prod = {64'd0, magnitude(d)} * {64'd0, magnitude(e)};
      inc  = (prod[127:96] != 0) ? '1 : prod[95:32];
      sum  = {1'b0, col_m2} + {1'b0, inc};
      col_m2 = sum[64] ? '1 : sum[63:0];
   endfunction

   // Apply one accepted cell; queue a result when it closes the column.
   function automatic void predict_cell(logic [1:0] kind, logic signed [31:0] val,
                                        logic last);
      column_result_type r;
      int unsigned total;
      logic [63:0] v;
      logic [63:0] root;
      longint      shifted;
      case (kind)
         css_pkg::KIND_MISSING: count_up(miss_cnt);
         css_pkg::KIND_WORD:    count_up(word_cnt);
         css_pkg::KIND_NUMBER:  add_number(val);
         default: ;
      endcase
      if (!last) return;
      r = '0;
      total = miss_cnt + word_cnt + num_cnt;
      if (total < 2 || word_cnt > 0) r.status = css_pkg::STAT_UNDEFINED;
      else if (miss_cnt > 0)         r.status = css_pkg::STAT_MISSING;
      else if (col_overflow)         r.status = css_pkg::STAT_OVERFLOW;
      else                           r.status = css_pkg::STAT_OK;
      if (r.status == css_pkg::STAT_OK) begin
         v = col_m2 / 64'(num_cnt - 1);
         if (v > {1'b0, VAR_MAX}) v = {1'b0, VAR_MAX};
         r.variance = v[62:0];
         root = floor_sqrt(v);
         r.std_deviation = (root > 64'h7FFF_FFFF) ? '1 : root[30:0];
         shifted = col_mean >>> 16;      // floor to Q16.16
         r.mean_value = shifted[31:0];
      end
      r.minimum       = num_cnt != 0 ? col_min : '0;
      r.maximum       = num_cnt != 0 ? col_max : '0;
      r.numeric_count = num_cnt  > 65535 ? 16'hFFFF : num_cnt[15:0];
      r.missing_count = miss_cnt > 65535 ? 16'hFFFF : miss_cnt[15:0];
      r.word_count    = word_cnt > 65535 ? 16'hFFFF : word_cnt[15:0];
      r.all_integer   = (num_cnt > 0 && whole_cnt == num_cnt);
      expected_results.push_back(r);
      clear_column();
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one cell beat, then maybe a gap at the end of a burst
   // ---------------------------------------------------------------------
   task automatic send_cell(logic [1:0] kind, logic signed [31:0] val, logic last);
      int gap;
      req_valid          <= 1'b1;
      req_cell_kind      <= kind;
      req_sample_value   <= val;
      req_last_in_column <= last;
      do @(posedge clock); while (req_stall);
      predict_cell(kind, val, last);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold off until every expected result has come, then idle a while
   task automatic wait_drained();
      end_burst();
      wait (expected_results.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;   // whole
         2:       return 32'($signed($urandom_range(0, 65535)) - 32768);
         default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Receiver stall pattern: phases of random length, each either no stall or random stall
   // ---------------------------------------------------------------------
   int stall_phase = 0;
   bit stall_mode  = 1'b0;
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_phase <= $urandom_range(20, 400);
         stall_mode  <= $urandom_range(0, 1);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch %s: expected %h got %h", name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      column_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result beat");
         end else begin
            exp_r = expected_results.pop_front();
            report_field("status",        exp_r.status,        rsp_status);
            report_field("mean_value",    exp_r.mean_value,    rsp_mean_value);
            report_field("variance",      exp_r.variance,      rsp_variance);
            report_field("std_deviation", exp_r.std_deviation, rsp_std_deviation);
            report_field("minimum",       exp_r.minimum,       rsp_minimum);
            report_field("maximum",       exp_r.maximum,       rsp_maximum);
            report_field("numeric_count", exp_r.numeric_count, rsp_numeric_count);
            report_field("missing_count", exp_r.missing_count, rsp_missing_count);
            report_field("word_count",    exp_r.word_count,    rsp_word_count);
            report_field("all_integer",   exp_r.all_integer,   rsp_all_integer);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_extremes();
      // full-scale values, fractions, equal values, one-cell and empty columns
      send_cell(css_pkg::KIND_NUMBER, 32'sh7FFF_FFFF, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, 32'sh8000_0000, 1'b1);
      send_cell(css_pkg::KIND_NUMBER, 32'sh0001_0000, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, 32'sh0001_0000, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, 32'sh0001_0000, 1'b1);   // zero variance, all whole
      send_cell(css_pkg::KIND_NUMBER, 32'sh0000_8000, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, -32'sh0000_0001, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, 32'sh0003_0001, 1'b1);   // fractions, one negative value
      send_cell(css_pkg::KIND_NUMBER, 32'sh1234_0000, 1'b1);   // single cell: undefined
      send_cell(KIND_UNUSED, 32'sh7FFF_FFFF, 1'b1);            // unused kind, empty column
      send_cell(css_pkg::KIND_NUMBER, 32'sh8000_0000, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, 32'sh8000_0000, 1'b0);
      send_cell(KIND_UNUSED, 32'sh0000_0000, 1'b1);            // unused kind closes column
      send_cell(css_pkg::KIND_NUMBER, 32'sh0005_0000, 1'b0);
      send_cell(css_pkg::KIND_WORD,   32'sh0000_0000, 1'b1);   // word forces undefined
      send_cell(css_pkg::KIND_NUMBER, 32'sh0005_0000, 1'b0);
      send_cell(css_pkg::KIND_MISSING, 32'sh0000_0000, 1'b1);  // missing cell status
      send_cell(css_pkg::KIND_MISSING, 32'sh0000_0000, 1'b0);
      send_cell(css_pkg::KIND_WORD,   32'sh0000_0000, 1'b1);   // undefined beats missing
      send_cell(css_pkg::KIND_NUMBER, 32'sh7FFF_FFFF, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, 32'sh8000_0000, 1'b0);
      send_cell(css_pkg::KIND_NUMBER, 32'sh7FFF_FFFF, 1'b1);
   endtask

   task automatic test_random_columns(int n_items);
      int sent, len, noise;
      logic [1:0] kind;
      sent = 0;
      while (sent < n_items) begin
         len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 6);
         noise = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            kind = css_pkg::KIND_NUMBER;
            if (noise) kind = 2'($urandom_range(0, 3));
            send_cell(kind, random_value(), i == len - 1);
            sent++;
         end
         if (sent > n_items / 2 && sent <= n_items / 2 + len) wait_drained();
      end
   endtask

   initial begin
      clear_column();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      wait_drained();
      test_random_columns(1000);
      wait_drained();
      if (error_count == 0 && expected_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
